FILE: src/float_half_conversion_defines.svh
// ---------------------------------------------------------------------------
// float_half_conversion_defines
// Assertion macros shared by the float/half converter RTL.
// ---------------------------------------------------------------------------
`ifndef FLOAT_HALF_CONVERSION_DEFINES_SVH
`define FLOAT_HALF_CONVERSION_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FHC_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("float_half_conversion: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define FHC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("float_half_conversion: assertion failed");

`endif

FILE: src/fhc_pkg.sv
// ---------------------------------------------------------------------------
// fhc_pkg
// Types and constants shared by the float/half converter modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fhc_pkg;

    // Single precision word and half precision word.
    typedef logic [31:0] word_t;
    typedef logic [15:0] half_t;

    // Conversion direction carried in tuser.
    typedef enum logic [0:0] {
        OP_S2H = 1'b0,
        OP_H2S = 1'b1
    } op_t;

    // Single to half: biased exponents in this range give a half denormal
    // that still holds some mantissa bits; below it the result is zero.
    localparam logic [7:0] S2H_DENORM_MAX_EXP = 8'd112;
    localparam logic [7:0] S2H_DENORM_MIN_EXP = 8'd103;
    localparam logic [7:0] S2H_DENORM_BASE    = 8'd113;

    // Half to single: exponent rebias, and the exponent of a normalized
    // half denormal whose leading one sits at mantissa bit 0.
    localparam logic [7:0] H2S_BIAS_ADJ       = 8'd112;
    localparam logic [7:0] H2S_DENORM_EXP_LO  = 8'd103;

endpackage

`default_nettype wire

FILE: src/fhc_single_to_half.sv
// ---------------------------------------------------------------------------
// fhc_single_to_half
// Truncating single to half conversion, pure combinational logic.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fhc_single_to_half
    import fhc_pkg::*;
(
    input  word_t value_bits,
    output word_t result_bits
);

    logic [7:0]  exp_f;
    logic [10:0] mant_top;
    logic [3:0]  shift_amt;
    logic [10:0] shifted;
    logic [13:0] low14;

    assign exp_f    = value_bits[30:23];
    assign mant_top = {1'b1, value_bits[22:13]};

    // Denormal shift; only small shifts keep any bits.
    assign shift_amt = 4'(S2H_DENORM_BASE - exp_f);
    assign shifted   = mant_top >> shift_amt;

    // Exponent field and mantissa, or denormal mantissa.
    always_comb begin
        if (exp_f <= S2H_DENORM_MAX_EXP) begin
            if (exp_f >= S2H_DENORM_MIN_EXP) begin
                low14 = {4'b0, shifted[9:0]};
            end else begin
                low14 = '0;
            end
        end else begin
            low14 = value_bits[26:13];
        end
    end

    // Sign and exponent bit 7 go to the top two half bits.
    assign result_bits = {16'b0, value_bits[31:30], low14};

endmodule

`default_nettype wire

FILE: src/fhc_half_to_single.sv
// ---------------------------------------------------------------------------
// fhc_half_to_single
// Half to single conversion with denormal normalization, combinational.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fhc_half_to_single
    import fhc_pkg::*;
(
    input  half_t half_bits,
    output word_t result_bits
);

    // Position of the highest set bit of a 10-bit mantissa.
    function automatic logic [3:0] msb_index(input logic [9:0] m);
        logic [3:0] idx;
        idx = '0;
        for (int i = 0; i < 10; i++) begin
            if (m[i]) begin
                idx = 4'(i);
            end
        end
        return idx;
    endfunction

    logic [4:0] exp_h;
    logic [9:0] mant_h;
    logic [3:0] msb;
    logic [3:0] norm_shift;
    logic [9:0] norm_mant;
    logic [7:0] norm_exp;
    logic [7:0] rebias_exp;

    assign exp_h  = half_bits[14:10];
    assign mant_h = half_bits[9:0];

    // Normalize a denormal so that its leading one becomes the hidden bit.
    assign msb        = msb_index(mant_h);
    assign norm_shift = 4'd10 - msb;
    assign norm_mant  = mant_h << norm_shift;
    assign norm_exp   = H2S_DENORM_EXP_LO + {4'b0, msb};

    // Normal halves just get the exponent rebiased.
    assign rebias_exp = {3'b0, exp_h} + H2S_BIAS_ADJ;

    always_comb begin
        if (exp_h != '0) begin
            result_bits = {half_bits[15], rebias_exp, mant_h, 13'b0};
        end else if (mant_h != '0) begin
            result_bits = {half_bits[15], norm_exp, norm_mant, 13'b0};
        end else begin
            result_bits = {half_bits[15], 31'b0};
        end
    end

endmodule

`default_nettype wire

FILE: src/float_half_conversion.sv
// A word accepted into the input register is converted combinationally and
// moves to the output register that drives m_tdata when the output stage is free.
// Throughput: one word per cycle while m_tready is high; one input register, the
// converters and one output register form a two-stage pipeline with chained ready.
// Reset: aresetn low at a clock edge empties both stages; words in flight are
// dropped and m_tvalid goes low.
// ---------------------------------------------------------------------------
// float_half_conversion
// Streaming single/half precision bit-pattern converter, either direction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "float_half_conversion_defines.svh"

module float_half_conversion
    import fhc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] value_bits
    input  wire logic        s_tuser,   // [0] operation

    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata    // [31:0] result_bits
);

    logic  in_valid_reg, in_valid_next;
    op_t   in_op_reg,    in_op_next;
    word_t in_data_reg,  in_data_next;
    logic  out_valid_reg, out_valid_next;
    word_t out_data_reg,  out_data_next;

    logic  out_free;
    logic  in_load;
    logic  advance;
    word_t s2h_result;
    word_t h2f_result;
    word_t conv_result;

    // Stage handshake: the output stage is free when empty or being read.
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign in_load  = s_tvalid && s_tready;

    // Converters.
    fhc_single_to_half u_s2h (
        .value_bits  (in_data_reg),
        .result_bits (s2h_result)
    );

    fhc_half_to_single u_h2f (
        .half_bits   (in_data_reg[15:0]),
        .result_bits (h2f_result)
    );

    assign conv_result = (in_op_reg == OP_H2S) ? h2f_result : s2h_result;

    // Input stage next values.
    always_comb begin
        in_valid_next = in_valid_reg;
        in_op_next    = in_op_reg;
        in_data_next  = in_data_reg;
        if (in_load) begin
            in_valid_next = 1'b1;
            in_op_next    = op_t'(s_tuser);
            in_data_next  = s_tdata;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    // Output stage next values.
    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (advance) begin
            out_valid_next = 1'b1;
            out_data_next  = conv_result;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    // Valid flags are cleared by reset; payload registers are not.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_op_reg    <= in_op_next;
        in_data_reg  <= in_data_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // A word leaving the input stage always lands in the output stage.
    `FHC_ASSERT_NEXT(a_advance_fills_out, aclk, aresetn, advance, m_tvalid)

    // A blocked input stage keeps its word.
    `FHC_ASSERT_NEXT(a_in_stage_holds, aclk, aresetn,
        in_valid_reg && !out_free, in_valid_reg && $stable(in_data_reg))

    // A half result never has upper bits set.
    `FHC_ASSERT_NEXT(a_s2h_upper_zero, aclk, aresetn,
        advance && (in_op_reg == OP_S2H), m_tdata[31:16] == 16'b0)

    // A nonzero half magnitude converts to a nonzero single exponent.
    `FHC_ASSERT_NEXT(a_h2f_exp_nonzero, aclk, aresetn,
        advance && (in_op_reg == OP_H2S) && (in_data_reg[14:0] != 15'b0),
        m_tdata[30:23] != 8'b0)

endmodule

`default_nettype wire

FILE: dv/tb_float_half_conversion.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_float_half_conversion
// Self-checking bench for the streaming single/half bit-pattern converter.
// Every accepted input word is run through an independent predictor, and the
// expected result is queued. Each result word is compared in order against
// that queue. Directed corner words come first, followed by random bursts.
// The bench adds random sender gaps, random receiver stalls, one long receiver
// hold-off, and a full drain in mid-run.
// ---------------------------------------------------------------------------

module tb_float_half_conversion;
    import fhc_pkg::*;

    // Scoreboard: predicts the converted word and checks results in order.
    class conv_scoreboard;
        localparam logic [7:0]  DENORM_EXP_MAX = 8'd112;
        localparam logic [7:0]  DENORM_BASE    = 8'd113;
        localparam logic [7:0]  SHIFT_LIMIT    = 8'd32;
        localparam logic [31:0] REBIAS         = 32'd112 << 23;
        localparam int          MAX_PRINTS     = 20;

        logic [31:0] pending_results[$];
        int          error_count;
        int          printed;

        function new();
            error_count = 0;
            printed = 0;
        endfunction

        // Truncating single to half: small exponents become denormals.
        function logic [31:0] half_from_single(logic [31:0] x);
            logic [7:0]  exp_field;
            logic [7:0]  shamt;
            logic [23:0] full_mant;
            logic [23:0] shifted;
            logic [15:0] h;
            exp_field = x[30:23];
            if (exp_field <= DENORM_EXP_MAX) begin
                shamt = DENORM_BASE - exp_field;
                full_mant = {1'b1, x[22:0]};
                shifted = (shamt >= SHIFT_LIMIT) ? 24'd0 : (full_mant >> shamt);
                h = 16'(shifted >> 13);
            end else begin
                h = {2'b00, x[26:13]};
            end
            h[15:14] = h[15:14] | x[31:30];
            return {16'h0000, h};
        endfunction

        // Half to single: rebias normals and normalize denormals.
        function logic [31:0] single_from_half(logic [31:0] x);
            logic [14:0] mag;
            logic [10:0] mant;
            logic [7:0]  lz;
            logic [31:0] f;
            mag = x[14:0];
            f = {x[15], 31'b0};
            if (mag > 15'h03ff) begin
                f = f | (({17'b0, mag} << 13) + REBIAS);
            end else if (mag != 15'd0) begin
                mant = mag[10:0];
                lz = 8'd0;
                for (int i = 0; i < 11 && !mant[10]; i++) begin
                    mant = mant << 1;
                    lz = lz + 8'd1;
                end
                f = f | {1'b0, DENORM_BASE - lz, mant[9:0], 13'b0};
            end
            return f;
        endfunction

        task report_mismatch(string msg);
            error_count++;
            if (printed < MAX_PRINTS) begin
                $display("[%0t] MISMATCH: %s", $time, msg);
                printed++;
            end
        endtask

        function void note_word(op_t op, logic [31:0] value);
            if (op == OP_S2H)
                pending_results.push_back(half_from_single(value));
            else
                pending_results.push_back(single_from_half(value));
        endfunction

        task check_word(logic [31:0] got);
            logic [31:0] want;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result word %08h with no conversion pending", got));
            end else begin
                want = pending_results.pop_front();
                if (want !== got)
                    report_mismatch($sformatf("result_bits %08h, expected %08h", got, want));
            end
        endtask

        task check_drained();
            if (pending_results.size() != 0)
                report_mismatch($sformatf("%0d result words never arrived",
                                          pending_results.size()));
        endtask

        function int outstanding();
            return pending_results.size();
        endfunction
    endclass

    typedef enum int {RX_STREAM, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_e;

    localparam int RANDOM_WORDS   = 1480;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 8;
    localparam int RUN_LIMIT_NS   = 2_000_000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = 32'h0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;

    logic        rx_hold_req = 1'b0;

    conv_scoreboard sb;

    float_half_conversion uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // 10 ns clock.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Watchdog for a hung pipeline.
    initial begin
        #(RUN_LIMIT_NS);
        $display("tb_float_half_conversion: errors");
        $finish;
    end

    // Both handshakes are observed at the rising edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                sb.note_word(op_t'(s_tuser), s_tdata);
            if (m_tvalid && m_tready)
                sb.check_word(m_tdata);
        end
    end

    // Result side: a changing stall pattern, plus a long hold-off on request.
    initial begin
        rx_mode_e mode;
        int       mode_left;
        int       hold_left;
        int       phase;
        mode = RX_STREAM;
        mode_left = 0;
        hold_left = 0;
        phase = 0;
        forever begin
            @(negedge aclk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode = rx_mode_e'($urandom_range(0, 3));
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                phase++;
                case (mode)
                    RX_STREAM:   m_tready <= 1'b1;
                    RX_COIN:     m_tready <= 1'($urandom_range(0, 1));
                    RX_SPARSE:   m_tready <= ($urandom_range(0, 3) == 0);
                    default:     m_tready <= (phase % 3 == 0);
                endcase
            end
        end
    end

    // Offer one word and hold it until it is taken.
    task send_word(op_t op, logic [31:0] value);
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= value;
        do @(posedge aclk); while (!s_tready);
    endtask

    task idle_for(int cycles);
        repeat (cycles) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
    endtask

    // Stop sending until every pending result has come back.
    task wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.outstanding() != 0)
            @(negedge aclk);
    endtask

    // Random source pattern, biased toward exponent boundaries.
    function automatic logic [31:0] pick_value(op_t op);
        logic [31:0] v;
        v = $urandom;
        if (op == OP_S2H) begin
            case ($urandom_range(0, 3))
                0: ;
                1: v[30:23] = 8'($urandom_range(80, 114));
                2: v[30:23] = 8'($urandom_range(113, 142));
                default: v[30:23] = 8'($urandom_range(0, 255));
            endcase
        end else begin
            case ($urandom_range(0, 3))
                0: ;
                1: begin
                    // Denormal halves with every leading-zero count.
                    v[14:10] = 5'd0;
                    v[9:0] = v[9:0] >> $urandom_range(0, 10);
                end
                2: v[14:10] = 5'h1f;
                default: v[14:10] = 5'($urandom_range(0, 2));
            endcase
        end
        return v;
    endfunction

    // Main stimulus.
    initial begin
        int burst_left;
        op_t op;
        sb = new();
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Single to half corners: zeros, all ones, boundaries of the denormal
        // range, shifts that empty the mantissa, and wrapping of big values.
        send_word(OP_S2H, 32'h0000_0000);
        send_word(OP_S2H, 32'h8000_0000);
        send_word(OP_S2H, 32'hffff_ffff);
        send_word(OP_S2H, 32'h7fff_ffff);
        send_word(OP_S2H, 32'h3f80_0000);
        send_word(OP_S2H, 32'h3880_0000);
        send_word(OP_S2H, 32'h387f_ffff);
        send_word(OP_S2H, 32'hb3ff_ffff);
        send_word(OP_S2H, 32'h337f_ffff);
        send_word(OP_S2H, 32'h2d7f_ffff);
        send_word(OP_S2H, 32'h28ff_ffff);
        send_word(OP_S2H, 32'h007f_ffff);
        send_word(OP_S2H, 32'h7f80_0000);
        send_word(OP_S2H, 32'h7fc0_0001);
        send_word(OP_S2H, 32'h477f_e000);
        send_word(OP_S2H, 32'hc780_0000);
        // Half to single corners: signed zero, denormal extremes, exponent
        // field 31, and upper input bits that must be ignored.
        send_word(OP_H2S, 32'h0000_0000);
        send_word(OP_H2S, 32'h0000_8000);
        send_word(OP_H2S, 32'h0000_0001);
        send_word(OP_H2S, 32'h0000_03ff);
        send_word(OP_H2S, 32'h0000_0400);
        send_word(OP_H2S, 32'h0000_7c00);
        send_word(OP_H2S, 32'h0000_ffff);
        send_word(OP_H2S, 32'habcd_3c00);
        send_word(OP_H2S, 32'hffff_8001);
        wait_drained();

        // Random bursts with gaps; one long result-side hold and one drain.
        burst_left = 0;
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n == 300) begin
                rx_hold_req = 1'b1;
                burst_left = 80;
            end else if (n == 800) begin
                wait_drained();
            end
            if (burst_left == 0) begin
                if ($urandom_range(0, 3) != 0)
                    idle_for($urandom_range(1, 8));
                burst_left = $urandom_range(1, 40);
            end
            burst_left--;
            op = op_t'($urandom_range(0, 1));
            send_word(op, pick_value(op));
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        sb.check_drained();
        if (sb.error_count == 0) begin
            $display("tb_float_half_conversion: clean");
        end else begin
            $display("tb_float_half_conversion: errors");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+src
src/fhc_pkg.sv
src/fhc_single_to_half.sv
src/fhc_half_to_single.sv
src/float_half_conversion.sv
dv/tb_float_half_conversion.sv
